FILE: rtl/core/psppp_pkg.sv
// Shared types and constants for the packed sample ping-pong player.
`timescale 1ns / 1ps

package psppp_pkg;

  localparam int BLOCKS_PER_PACKET  = 6;
  localparam int SAMPLES_PER_BUFFER = 24;
  localparam int SAMPLES_PER_BLOCK  = 4;

  localparam int SAMPLE_W = 10;
  localparam int DUTY_W   = 11;
  localparam int BYTE_W   = 8;

  localparam int RIDX_W = $clog2(SAMPLES_PER_BUFFER);
  localparam int BIDX_W = (BLOCKS_PER_PACKET > 1) ? $clog2(BLOCKS_PER_PACKET) : 1;
  localparam int POS_W  = $clog2(SAMPLES_PER_BLOCK * BLOCKS_PER_PACKET + SAMPLES_PER_BUFFER);

  typedef enum logic {
    KIND_TICK  = 1'b0,
    KIND_BLOCK = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t                                 kind;
    logic [BYTE_W-1:0]                     high_bits_byte;
    logic [SAMPLES_PER_BLOCK-1:0][BYTE_W-1:0] low_bytes;
  } item_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              duty_valid;
    logic              play_buffer;
  } result_t;

endpackage

FILE: rtl/core/psppp_in_reg.sv
// Input register stage: holds one accepted transaction until it can advance.
`timescale 1ns / 1ps

module psppp_in_reg
  import psppp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_stall,
  input  item_t item_in,
  input  logic  out_free,
  output logic  advance,
  output item_t item_q
);

  logic full;

  assign advance    = full && ((item_q.kind == KIND_BLOCK) || out_free);
  assign item_stall = full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (!item_stall) begin
      full <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      item_q <= item_in;
    end
  end

endmodule

FILE: rtl/core/psppp_engine.sv
// Sample stores, fill/play control and per-tick result computation.
`timescale 1ns / 1ps

module psppp_engine
  import psppp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  item_t   item,
  output result_t result
);

  logic [SAMPLE_W-1:0] store_a [SAMPLES_PER_BUFFER];
  logic [SAMPLE_W-1:0] store_b [SAMPLES_PER_BUFFER];
  logic [SAMPLE_W-1:0] store_a_next [SAMPLES_PER_BUFFER];
  logic [SAMPLE_W-1:0] store_b_next [SAMPLES_PER_BUFFER];
  logic [RIDX_W-1:0]   read_index_a, read_index_a_next;
  logic [RIDX_W-1:0]   read_index_b, read_index_b_next;
  logic                fill_select, fill_select_next;
  logic                play_select, play_select_next;
  logic [BIDX_W-1:0]   block_index, block_index_next;
  logic                playing, playing_next;

  logic [SAMPLES_PER_BLOCK-1:0][SAMPLE_W-1:0] samples;
  logic [SAMPLES_PER_BLOCK-1:0][POS_W-1:0]    pos;
  logic [POS_W-1:0]    base;
  logic [RIDX_W-1:0]   cur_idx;
  logic [SAMPLE_W-1:0] cur_sample;

  always_comb begin
    for (int j = 0; j < SAMPLES_PER_BLOCK; j++) begin
      samples[j] = {item.high_bits_byte[BYTE_W-1-2*j -: 2], item.low_bytes[j]};
    end
  end

  assign base = POS_W'({block_index, 2'b00});

  always_comb begin
    for (int j = 0; j < SAMPLES_PER_BLOCK; j++) begin
      pos[j] = base + POS_W'(j);
    end
  end

  assign cur_idx    = play_select ? read_index_b : read_index_a;
  assign cur_sample = play_select ? store_b[cur_idx] : store_a[cur_idx];

  always_comb begin
    store_a_next       = store_a;
    store_b_next       = store_b;
    read_index_a_next  = read_index_a;
    read_index_b_next  = read_index_b;
    fill_select_next   = fill_select;
    play_select_next   = play_select;
    block_index_next   = block_index;
    playing_next       = playing;
    result.duty        = '0;
    result.duty_valid  = 1'b0;
    if (advance && item.kind == KIND_BLOCK) begin
      for (int e = 0; e < SAMPLES_PER_BUFFER; e++) begin
        for (int j = 0; j < SAMPLES_PER_BLOCK; j++) begin
          if (pos[j] == POS_W'(e)) begin
            if (fill_select) begin
              store_b_next[e] = samples[j];
            end else begin
              store_a_next[e] = samples[j];
            end
          end
        end
      end
      if (fill_select) begin
        read_index_b_next = '0;
      end else begin
        read_index_a_next = '0;
      end
      if (block_index == BIDX_W'(BLOCKS_PER_PACKET - 1)) begin
        block_index_next = '0;
        fill_select_next = !fill_select;
        playing_next     = 1'b1;
      end else begin
        block_index_next = block_index + 1'b1;
      end
    end else if (advance && playing) begin
      result.duty       = {cur_sample, 1'b0};
      result.duty_valid = 1'b1;
      if (cur_idx == RIDX_W'(SAMPLES_PER_BUFFER - 1)) begin
        play_select_next = !play_select;
        if (play_select) begin
          read_index_b_next = '0;
        end else begin
          read_index_a_next = '0;
        end
      end else if (play_select) begin
        read_index_b_next = cur_idx + 1'b1;
      end else begin
        read_index_a_next = cur_idx + 1'b1;
      end
    end
    result.play_buffer = play_select_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int e = 0; e < SAMPLES_PER_BUFFER; e++) begin
        store_a[e] <= '0;
        store_b[e] <= '0;
      end
      read_index_a <= '0;
      read_index_b <= '0;
      fill_select  <= 1'b0;
      play_select  <= 1'b0;
      block_index  <= '0;
      playing      <= 1'b0;
    end else begin
      store_a      <= store_a_next;
      store_b      <= store_b_next;
      read_index_a <= read_index_a_next;
      read_index_b <= read_index_b_next;
      fill_select  <= fill_select_next;
      play_select  <= play_select_next;
      block_index  <= block_index_next;
      playing      <= playing_next;
    end
  end

endmodule

FILE: rtl/core/psppp_out_reg.sv
// Result register: holds one tick result until the receiver takes it.
`timescale 1ns / 1ps

module psppp_out_reg
  import psppp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t result_in,
  output logic    out_free,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result_q
);

  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && load) begin
      result_q <= result_in;
    end
  end

endmodule

FILE: rtl/core/packed_sample_ping_pong_player_core.sv
// Top level of the packed sample ping-pong player.
//
//  channel | handshake                  | payload
//  --------+----------------------------+------------------------------------------
//  item    | item_valid / item_stall    | kind, high_bits_byte, low_byte_0..3
//  result  | result_valid / result_stall| duty, duty_valid, play_buffer
//
// One transaction per cycle sustained while item_stall is low; a tick passes the input
// register, then the result register, before its result is on the result ports.
// Block transactions give no result and never wait on the result side. Synchronous
// reset clears both sample stores and all control. While a result is stalled, blocks
// still pass; the first tick behind it waits in the input register and raises item_stall.
`timescale 1ns / 1ps

module packed_sample_ping_pong_player_core
  import psppp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic                kind,
  input  logic [BYTE_W-1:0]   high_bits_byte,
  input  logic [BYTE_W-1:0]   low_byte_0,
  input  logic [BYTE_W-1:0]   low_byte_1,
  input  logic [BYTE_W-1:0]   low_byte_2,
  input  logic [BYTE_W-1:0]   low_byte_3,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [DUTY_W-1:0]   duty,
  output logic                duty_valid,
  output logic                play_buffer
);

  item_t   item_in;
  item_t   item_q;
  result_t result_next;
  result_t result_q;
  logic    advance;
  logic    out_free;

  assign item_in.kind           = kind_t'(kind);
  assign item_in.high_bits_byte = high_bits_byte;
  assign item_in.low_bytes      = {low_byte_3, low_byte_2, low_byte_1, low_byte_0};

  psppp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item_in    (item_in),
    .out_free   (out_free),
    .advance    (advance),
    .item_q     (item_q)
  );

  psppp_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item_q),
    .result  (result_next)
  );

  psppp_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (advance && item_q.kind == KIND_TICK),
    .result_in    (result_next),
    .out_free     (out_free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_q     (result_q)
  );

  assign duty        = result_q.duty;
  assign duty_valid  = result_q.duty_valid;
  assign play_buffer = result_q.play_buffer;

endmodule
